// ===== hdl/ktrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ktrd_pkg
// Shared types, widths and register codes for the key tap / repeat detector.
// ----------------------------------------------------------------------------
package ktrd_pkg;

    localparam int KEY_W      = 8;
    localparam int ELAPSED_W  = 16;
    localparam int TIMER_W    = 20;
    localparam int CFG_IDX_W  = 2;

    localparam int NUM_KEYS_DEF = 256;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPT_INTERVAL = 2'd2;

    localparam logic [TIMER_W-1:0] DBL_WINDOW_RST   = 20'd200;
    localparam logic [TIMER_W-1:0] RPT_DELAY_RST    = 20'd500;
    localparam logic [TIMER_W-1:0] RPT_INTERVAL_RST = 20'd50;

    typedef struct packed {
        logic [TIMER_W-1:0] dbl_window;
        logic [TIMER_W-1:0] rpt_delay;
        logic [TIMER_W-1:0] rpt_interval;
    } t_cfg;

    // per-key state word as stored in the state RAM
    typedef struct packed {
        logic               level;
        logic [TIMER_W-1:0] since_tap;
        logic [TIMER_W-1:0] rpt_acc;
        logic               first_rpt;
    } t_key_state;

    localparam t_key_state KEY_STATE_RST = '{
        level:     1'b0,
        since_tap: TIMER_MAX,
        rpt_acc:   '0,
        first_rpt: 1'b0
    };

    typedef struct packed {
        logic tapped;
        logic released;
        logic double_tapped;
        logic repeat_pulse;
    } t_flags;

endpackage

// ===== hdl/ktrd_if.sv =====
// ----------------------------------------------------------------------------
// ktrd_if
// Stream and configuration interfaces of the key tap / repeat detector.
// ----------------------------------------------------------------------------
interface ktrd_key_if;
    logic                         valid;
    logic                         ready;
    logic [ktrd_pkg::KEY_W-1:0]     key_index;
    logic                         key_down;
    logic [ktrd_pkg::ELAPSED_W-1:0] poll_elapsed;

    modport source (output valid, key_index, key_down, poll_elapsed, input ready);
    modport sink   (input valid, key_index, key_down, poll_elapsed, output ready);
    modport monitor (input valid, ready, key_index, key_down, poll_elapsed);
endinterface

interface ktrd_res_if;
    logic                     valid;
    logic                     ready;
    logic [ktrd_pkg::KEY_W-1:0] key_id;
    logic                     is_down;
    logic                     tapped;
    logic                     released;
    logic                     double_tapped;
    logic                     repeat_pulse;

    modport source (output valid, key_id, is_down, tapped, released, double_tapped,
                    repeat_pulse, input ready);
    modport sink   (input valid, key_id, is_down, tapped, released, double_tapped,
                    repeat_pulse, output ready);
    modport monitor (input valid, ready, key_id, is_down, tapped, released,
                     double_tapped, repeat_pulse);
endinterface

interface ktrd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ktrd_pkg::CFG_IDX_W-1:0] reg_index;
    logic [ktrd_pkg::TIMER_W-1:0]   wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hdl/ktrd_ram.sv =====
// ----------------------------------------------------------------------------
// ktrd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ktrd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ktrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ktrd_cfg_regs
// Timing configuration registers, written by index over the config channel.
// ----------------------------------------------------------------------------
module ktrd_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ktrd_cfg_if.sink       i_cfg,
    output ktrd_pkg::t_cfg o_cfg
);
    import ktrd_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dbl_window   <= DBL_WINDOW_RST;
            r_cfg.rpt_delay    <= RPT_DELAY_RST;
            r_cfg.rpt_interval <= RPT_INTERVAL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_DBL_WINDOW:   r_cfg.dbl_window   <= i_cfg.wr_data;
                CFG_RPT_DELAY:    r_cfg.rpt_delay    <= i_cfg.wr_data;
                CFG_RPT_INTERVAL: r_cfg.rpt_interval <= i_cfg.wr_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/ktrd_eval.sv =====
// ----------------------------------------------------------------------------
// ktrd_eval
// Per-key update: edge detect, double-tap window test and typematic repeat.
// ----------------------------------------------------------------------------
module ktrd_eval (
    input  ktrd_pkg::t_key_state             i_cur,
    input  logic                             i_down,
    input  logic [ktrd_pkg::ELAPSED_W-1:0]   i_elapsed,
    input  ktrd_pkg::t_cfg                   i_cfg,
    output ktrd_pkg::t_key_state             o_nxt,
    output ktrd_pkg::t_flags                 o_flags
);
    import ktrd_pkg::*;

    logic [TIMER_W:0]   tmr_sum;
    logic [TIMER_W:0]   acc_sum;
    logic [TIMER_W-1:0] tmr_sat;
    logic [TIMER_W-1:0] acc_sat;
    logic [TIMER_W-1:0] thr;
    logic               tap;

    assign tmr_sum = {1'b0, i_cur.since_tap} + (TIMER_W+1)'(i_elapsed);
    assign acc_sum = {1'b0, i_cur.rpt_acc}   + (TIMER_W+1)'(i_elapsed);
    assign tmr_sat = tmr_sum[TIMER_W] ? TIMER_MAX : tmr_sum[TIMER_W-1:0];
    assign acc_sat = acc_sum[TIMER_W] ? TIMER_MAX : acc_sum[TIMER_W-1:0];
    assign thr     = i_cur.first_rpt ? i_cfg.rpt_delay : i_cfg.rpt_interval;
    assign tap     = i_down && !i_cur.level;

    always_comb begin
        o_nxt                  = i_cur;
        o_nxt.level            = i_down;
        o_nxt.since_tap        = tmr_sat;
        o_flags.tapped         = tap;
        o_flags.released       = !i_down && i_cur.level;
        o_flags.double_tapped  = 1'b0;
        o_flags.repeat_pulse   = 1'b0;
        priority if (tap) begin
            o_flags.double_tapped = (tmr_sat <= i_cfg.dbl_window);
            o_flags.repeat_pulse  = 1'b1;
            o_nxt.since_tap       = '0;
            o_nxt.rpt_acc         = '0;
            o_nxt.first_rpt       = 1'b1;
        end else if (i_down) begin
            if (acc_sat > thr) begin
                o_flags.repeat_pulse = 1'b1;
                o_nxt.rpt_acc        = '0;
                o_nxt.first_rpt      = 1'b0;
            end else begin
                o_nxt.rpt_acc = acc_sat;
            end
        end else begin
            // key up: accumulator and first-repeat flag hold
        end
    end

endmodule

// ===== hdl/key_tap_repeat_detector.sv =====
// ----------------------------------------------------------------------------
// key_tap_repeat_detector
// Per-key tap, release, double-tap and typematic repeat detection.
// ----------------------------------------------------------------------------
// Usage:
//   i_key carries one key sample per beat (index, level, elapsed poll time);
//   o_res returns exactly one result beat per sample, in order. i_cfg writes
//   the double-tap window, initial repeat delay and repeat interval by index;
//   write it only while no sample is in flight.
//   A sample passes the read stage (registered read of the per-key state RAM)
//   and then the result register (update into the result register). Throughput
//   is one sample per cycle while o_res is not stalled, also for repeated
//   samples of the same key (the last state write is forwarded).
//   Reset clears the control flops and the per-key valid bits; a key that was
//   never written reads as released with a saturated tap timer, so no
//   clearing pass is needed and samples are taken right after reset.
//   When o_res is stalled, one more sample is taken into the read stage and
//   then i_key.ready drops until the result register drains.
//   Samples with a key index at or above NUM_KEYS are echoed with all event
//   flags low and leave state untouched.
// ----------------------------------------------------------------------------
module key_tap_repeat_detector #(
    parameter int NUM_KEYS = ktrd_pkg::NUM_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ktrd_key_if.sink    i_key,
    ktrd_res_if.source  o_res,
    ktrd_cfg_if.sink    i_cfg
);
    import ktrd_pkg::*;

    localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int SW = $bits(t_key_state);

    t_cfg cfg;

    ktrd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // ---------------- accept / read stage ----------------
    logic                 in_acc;
    logic                 in_range;
    logic [AW-1:0]        in_addr;
    logic                 s1_adv;
    logic                 wr_en;

    logic                 r_s1_v;
    logic [KEY_W-1:0]     r_s1_key;
    logic                 r_s1_down;
    logic [ELAPSED_W-1:0] r_s1_elapsed;
    logic                 r_s1_inr;
    logic                 r_s1_ent_vld;

    logic [NUM_KEYS-1:0]  r_ent_vld;
    logic                 r_fwd_v;
    logic [AW-1:0]        r_fwd_addr;
    t_key_state           r_fwd_state;

    logic                 r_o_v;
    logic [KEY_W-1:0]     r_o_key;
    logic                 r_o_down;
    t_flags               r_o_flags;

    logic [SW-1:0]        rd_data;
    logic [AW-1:0]        s1_addr;
    t_key_state           cur_state;
    t_key_state           nxt_state;
    t_flags               flags;

    assign in_addr  = i_key.key_index[AW-1:0];
    assign in_range = ({1'b0, i_key.key_index} < (KEY_W+1)'(NUM_KEYS));
    assign s1_adv   = r_s1_v && (!r_o_v || o_res.ready);
    assign i_key.ready = !r_s1_v || s1_adv;
    assign in_acc   = i_key.valid && i_key.ready;
    assign s1_addr  = r_s1_key[AW-1:0];
    assign wr_en    = s1_adv && r_s1_inr;

    ktrd_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_KEYS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_addr),
        .i_wr_data (nxt_state),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data)
    );

    // newest write wins over the RAM read; never-written entries read as reset
    always_comb begin
        priority if (r_fwd_v && (r_fwd_addr == s1_addr)) begin
            cur_state = r_fwd_state;
        end else if (r_s1_ent_vld) begin
            cur_state = t_key_state'(rd_data);
        end else begin
            cur_state = KEY_STATE_RST;
        end
    end

    ktrd_eval u_eval (
        .i_cur     (cur_state),
        .i_down    (r_s1_down),
        .i_elapsed (r_s1_elapsed),
        .i_cfg     (cfg),
        .o_nxt     (nxt_state),
        .o_flags   (flags)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_o_v     <= 1'b0;
            r_fwd_v   <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_o_v <= 1'b1;
            end else if (o_res.ready) begin
                r_o_v <= 1'b0;
            end
            if (wr_en) begin
                r_fwd_v            <= 1'b1;
                r_ent_vld[s1_addr] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_key     <= i_key.key_index;
            r_s1_down    <= i_key.key_down;
            r_s1_elapsed <= i_key.poll_elapsed;
            r_s1_inr     <= in_range;
            r_s1_ent_vld <= in_range ? r_ent_vld[in_addr] : 1'b0;
        end
        if (wr_en) begin
            r_fwd_addr  <= s1_addr;
            r_fwd_state <= nxt_state;
        end
        if (s1_adv) begin
            r_o_key   <= r_s1_key;
            r_o_down  <= r_s1_down;
            r_o_flags <= r_s1_inr ? flags : '0;
        end
    end

    assign o_res.valid         = r_o_v;
    assign o_res.key_id        = r_o_key;
    assign o_res.is_down       = r_o_down;
    assign o_res.tapped        = r_o_flags.tapped;
    assign o_res.released      = r_o_flags.released;
    assign o_res.double_tapped = r_o_flags.double_tapped;
    assign o_res.repeat_pulse  = r_o_flags.repeat_pulse;

endmodule

// ===== hdl/ktrd_checker.sv =====
// ----------------------------------------------------------------------------
// ktrd_checker
// Port-level checks for the key tap / repeat detector, bound to the top.
// ----------------------------------------------------------------------------
module ktrd_checker #(
    parameter int NUM_KEYS = ktrd_pkg::NUM_KEYS_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_key_valid,
    input logic                       i_key_ready,
    input logic                       i_res_valid,
    input logic                       i_res_ready,
    input logic [ktrd_pkg::KEY_W-1:0] i_res_key_id,
    input logic                       i_res_is_down,
    input logic                       i_res_tapped,
    input logic                       i_res_released,
    input logic                       i_res_double_tapped,
    input logic                       i_res_repeat_pulse
);
    import ktrd_pkg::*;

    logic       in_beat;
    logic       out_beat;
    logic [1:0] r_cnt;   // samples taken, results not yet delivered

    assign in_beat  = i_key_valid && i_key_ready;
    assign out_beat = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_key_id)
            && $stable(i_res_is_down) && $stable(i_res_tapped)
            && $stable(i_res_released) && $stable(i_res_double_tapped)
            && $stable(i_res_repeat_pulse))
        else $error("result beat changed while stalled");

    a_tap_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_tapped |->
            i_res_is_down && i_res_repeat_pulse && !i_res_released)
        else $error("tap without down level or tap pulse");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && ({1'b0, i_res_key_id} >= (KEY_W+1)'(NUM_KEYS)) |->
            !(i_res_tapped || i_res_released || i_res_double_tapped
              || i_res_repeat_pulse))
        else $error("event flag on key outside the key range");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != 2'd3) && ((r_cnt != 2'd0) || (i_key_ready && !i_res_valid)))
        else $error("result count out of step with accepted samples");

endmodule

bind key_tap_repeat_detector ktrd_checker #(.NUM_KEYS(NUM_KEYS)) u_ktrd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_key_valid         (i_key.valid),
    .i_key_ready         (i_key.ready),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_res_key_id        (o_res.key_id),
    .i_res_is_down       (o_res.is_down),
    .i_res_tapped        (o_res.tapped),
    .i_res_released      (o_res.released),
    .i_res_double_tapped (o_res.double_tapped),
    .i_res_repeat_pulse  (o_res.repeat_pulse)
);

// ===== dv/key_tap_repeat_detector_test.sv =====
// ----------------------------------------------------------------------------
// key_tap_repeat_detector_test
// Self-checking bench for the key tap / repeat detector. A short table of
// directed key samples and register writes runs first. Typing-like polls over
// several register settings follow: a handful of keys are pressed, held and
// released, with stray samples mixed in. Every result beat is checked field by
// field in order against pinned table flags or an in-bench per-key timer model.
// ----------------------------------------------------------------------------
module key_tap_repeat_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ktrd_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int NUM_KEYS       = NUM_KEYS_DEF;
    localparam int RANDOM_SAMPLES = 1650;
    localparam int N_PHASES       = 9;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 500000;

    typedef struct packed {
        logic [KEY_W-1:0] key_id;
        logic             is_down;
        logic             tapped;
        logic             released;
        logic             double_tapped;
        logic             repeat_pulse;
    } t_tap_report;

    typedef struct {
        bit          pinned;
        t_tap_report report;
    } t_typed_answer;

    typedef enum logic {ROW_SAMPLE, ROW_REG_WRITE} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [TIMER_W-1:0]     reg_data;
        logic [KEY_W-1:0]       key;
        logic                   down;
        logic [ELAPSED_W-1:0]   elapsed;
        bit                     pinned;
        t_flags                 flags;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ktrd_key_if key_bus ();
    ktrd_res_if res_bus ();
    ktrd_cfg_if cfg_bus ();

    key_tap_repeat_detector i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // model of the per-key state and the registers
    logic               key_level     [NUM_KEYS] = '{default: KEY_STATE_RST.level};
    logic [TIMER_W-1:0] since_tap     [NUM_KEYS] = '{default: KEY_STATE_RST.since_tap};
    logic [TIMER_W-1:0] repeat_acc    [NUM_KEYS] = '{default: KEY_STATE_RST.rpt_acc};
    logic               first_pending [NUM_KEYS] = '{default: KEY_STATE_RST.first_rpt};
    logic [TIMER_W-1:0] cfg_window   = DBL_WINDOW_RST;
    logic [TIMER_W-1:0] cfg_delay    = RPT_DELAY_RST;
    logic [TIMER_W-1:0] cfg_interval = RPT_INTERVAL_RST;

    t_tap_report   pending_reports[$];
    t_typed_answer typed_answers[$];

    int err_count    = 0;
    int cycle_count  = 0;
    int samples_seen = 0;
    int regs_written = 0;
    int taps_seen    = 0;
    int doubles_seen = 0;
    int pulses_seen  = 0;
    bit tx_burst;
    bit rx_burst;

    function automatic logic [TIMER_W-1:0] add_clamped(logic [TIMER_W-1:0] a,
                                                       logic [ELAPSED_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + (TIMER_W+1)'(b);
        return (s > {1'b0, TIMER_MAX}) ? TIMER_MAX : s[TIMER_W-1:0];
    endfunction

    function automatic t_tap_report predict_sample(logic [KEY_W-1:0] key, logic down,
                                                   logic [ELAPSED_W-1:0] el);
        t_tap_report        r;
        logic [TIMER_W-1:0] thr;
        r         = '0;
        r.key_id  = key;
        r.is_down = down;
        if (int'(key) < NUM_KEYS) begin
            r.tapped   = down && !key_level[key];
            r.released = !down && key_level[key];
            since_tap[key] = add_clamped(since_tap[key], el);
            if (r.tapped) begin
                r.double_tapped    = (since_tap[key] <= cfg_window);
                r.repeat_pulse     = 1'b1;
                since_tap[key]     = '0;
                repeat_acc[key]    = '0;
                first_pending[key] = 1'b1;
            end else if (down) begin
                thr = first_pending[key] ? cfg_delay : cfg_interval;
                repeat_acc[key] = add_clamped(repeat_acc[key], el);
                if (repeat_acc[key] > thr) begin
                    r.repeat_pulse     = 1'b1;
                    repeat_acc[key]    = '0;
                    first_pending[key] = 1'b0;
                end
            end
            key_level[key] = down;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want, input logic [KEY_W-1:0] key);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d (key %0d)",
                                      name, got, want, key));
    endtask

    // ------------------------------------------------------------------
    // port watch: registers, accepted samples and result beats
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        t_tap_report   want;
        t_tap_report   got;
        t_typed_answer typed;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                regs_written++;
                case (cfg_bus.reg_index)
                    CFG_DBL_WINDOW:   cfg_window   = cfg_bus.wr_data;
                    CFG_RPT_DELAY:    cfg_delay    = cfg_bus.wr_data;
                    CFG_RPT_INTERVAL: cfg_interval = cfg_bus.wr_data;
                    default: ;
                endcase
            end
            if (key_bus.valid && key_bus.ready) begin
                want = predict_sample(key_bus.key_index, key_bus.key_down,
                                      key_bus.poll_elapsed);
                if (typed_answers.size() != 0) begin
                    typed = typed_answers.pop_front();
                    if (typed.pinned)
                        want = typed.report;
                end
                samples_seen++;
                taps_seen    += int'(want.tapped);
                doubles_seen += int'(want.double_tapped);
                pulses_seen  += int'(want.repeat_pulse);
                pending_reports.push_back(want);
            end
            if (res_bus.valid && res_bus.ready) begin
                got = '{res_bus.key_id, res_bus.is_down, res_bus.tapped, res_bus.released,
                        res_bus.double_tapped, res_bus.repeat_pulse};
                if (pending_reports.size() == 0) begin
                    report_mismatch($sformatf("result beat for key %0d with none outstanding",
                                              got.key_id));
                end else begin
                    want = pending_reports.pop_front();
                    check_field("key_id", got.key_id, want.key_id, want.key_id);
                    check_field("is_down", got.is_down, want.is_down, want.key_id);
                    check_field("tapped", got.tapped, want.tapped, want.key_id);
                    check_field("released", got.released, want.released, want.key_id);
                    check_field("double_tapped", got.double_tapped, want.double_tapped,
                                want.key_id);
                    check_field("repeat_pulse", got.repeat_pulse, want.repeat_pulse,
                                want.key_id);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall before each beat, none while rx_burst is set
    initial begin
        int stall;
        res_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 18);
            if (stall != 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_bus.valid) @(posedge i_clk);
        end
    end

    // valid stays high from one beat to the next when there is no gap
    task automatic send_sample(input logic [KEY_W-1:0] key, input logic down,
                               input logic [ELAPSED_W-1:0] el, input bit pinned,
                               input t_flags flags);
        int            gap;
        t_typed_answer typed;
        gap = tx_burst ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            key_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed.pinned = pinned;
        typed.report = '{key, down, flags.tapped, flags.released, flags.double_tapped,
                         flags.repeat_pulse};
        typed_answers.push_back(typed);
        key_bus.valid        <= 1'b1;
        key_bus.key_index    <= key;
        key_bus.key_down     <= down;
        key_bus.poll_elapsed <= el;
        @(posedge i_clk);
        while (!key_bus.ready) @(posedge i_clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TIMER_W-1:0] data);
        key_bus.valid <= 1'b0;
        while (pending_reports.size() != 0 || typed_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= idx;
        cfg_bus.wr_data   <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        case ($urandom_range(0, 19))
            0, 1:      return '0;
            2:         return '1;
            3, 4:      return ELAPSED_W'($urandom);
            5, 6:      return ELAPSED_W'($urandom_range(32768, 65535));
            7, 8, 9, 10, 11, 12, 13: return ELAPSED_W'($urandom_range(0, 63));
            default:   return ELAPSED_W'($urandom_range(0, 511));
        endcase
    endfunction

    // polls over a few keys: press, hold, release runs, plus stray samples
    task automatic run_typing_phase(input int n_samples);
        logic [KEY_W-1:0]     keys    [6];
        logic                 lvl     [6];
        int                   run_left[6];
        int                   n_keys;
        int                   done;
        int                   polls;
        logic [ELAPSED_W-1:0] el;
        n_keys = $urandom_range(1, 6);
        for (int k = 0; k < 6; k++) begin
            keys[k]     = KEY_W'($urandom_range(0, 255));
            lvl[k]      = 1'b0;
            run_left[k] = $urandom_range(0, 3);
        end
        done  = 0;
        polls = 0;
        while (done < n_samples) begin
            if (polls % 12 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            polls++;
            el = pick_elapsed();
            if ($urandom_range(0, 9) == 0) begin
                send_sample(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            ELAPSED_W'($urandom), 1'b0, '0);
                done++;
            end
            if ($urandom_range(0, 19) == 0)
                keys[$urandom_range(0, n_keys - 1)] = KEY_W'($urandom_range(0, 255));
            for (int k = 0; k < n_keys; k++) begin
                if (run_left[k] == 0) begin
                    lvl[k] = !lvl[k];
                    if (lvl[k])
                        run_left[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                                  : $urandom_range(1, 10);
                    else
                        run_left[k] = $urandom_range(1, 4);
                end else begin
                    run_left[k]--;
                end
                // now and then a key misses a poll
                if ($urandom_range(0, 15) != 0) begin
                    send_sample(keys[k], lvl[k], el, 1'b0, '0);
                    done++;
                end
            end
        end
    endtask

    function automatic t_stim_row sample_row(logic [KEY_W-1:0] key, logic down,
                                             logic [ELAPSED_W-1:0] el);
        t_stim_row r;
        r         = '{kind: ROW_SAMPLE, default: '0};
        r.key     = key;
        r.down    = down;
        r.elapsed = el;
        return r;
    endfunction

    // flags are {tapped, released, double_tapped, repeat_pulse}
    function automatic t_stim_row pinned_row(logic [KEY_W-1:0] key, logic down,
                                             logic [ELAPSED_W-1:0] el, logic [3:0] flags);
        t_stim_row r;
        r        = sample_row(key, down, el);
        r.pinned = 1'b1;
        r.flags  = t_flags'(flags);
        return r;
    endfunction

    function automatic t_stim_row reg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [TIMER_W-1:0] data);
        t_stim_row r;
        r           = '{kind: ROW_REG_WRITE, default: '0};
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    initial begin
        t_stim_row          rows[$];
        logic [TIMER_W-1:0] w;
        logic [TIMER_W-1:0] d;
        logic [TIMER_W-1:0] iv;

        tx_burst     = 1'b0;
        rx_burst     = 1'b0;

        key_bus.valid        <= 1'b0;
        key_bus.key_index    <= '0;
        key_bus.key_down     <= 1'b0;
        key_bus.poll_elapsed <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.reg_index    <= CFG_DBL_WINDOW;
        cfg_bus.wr_data      <= '0;
        i_rst_n              <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: delay 500 is passed only by 501, interval 50 by 51
        rows.push_back(pinned_row(8'd0, 1'b1, 16'd0, 4'b1001));
        rows.push_back(pinned_row(8'd0, 1'b1, 16'd500, 4'b0000));
        rows.push_back(pinned_row(8'd0, 1'b1, 16'd1, 4'b0001));
        rows.push_back(pinned_row(8'd0, 1'b1, 16'd51, 4'b0001));
        rows.push_back(pinned_row(8'd0, 1'b0, 16'd0, 4'b0100));
        rows.push_back(sample_row(8'd0, 1'b1, 16'd0));
        rows.push_back(sample_row(8'd0, 1'b0, 16'd100));
        // second tap exactly at the window edge
        rows.push_back(pinned_row(8'd0, 1'b1, 16'd100, 4'b1011));
        rows.push_back(pinned_row(8'd255, 1'b1, 16'hFFFF, 4'b1001));
        rows.push_back(pinned_row(8'd255, 1'b1, 16'hFFFF, 4'b0001));
        rows.push_back(pinned_row(8'd255, 1'b0, 16'hFFFF, 4'b0100));
        rows.push_back(pinned_row(8'd170, 1'b0, 16'hFFFF, 4'b0000));
        rows.push_back(sample_row(8'd85, 1'b1, 16'd0));
        rows.push_back(pinned_row(8'd85, 1'b1, 16'd0, 4'b0000));
        // widest window: even a first tap with a saturated timer is a double
        rows.push_back(reg_row(CFG_DBL_WINDOW, TIMER_MAX));
        rows.push_back(reg_row(CFG_RPT_DELAY, TIMER_MAX));
        rows.push_back(pinned_row(8'd7, 1'b1, 16'd0, 4'b1011));
        rows.push_back(sample_row(8'd7, 1'b1, 16'hFFFF));
        rows.push_back(sample_row(8'd7, 1'b0, 16'hFFFF));
        rows.push_back(sample_row(8'd7, 1'b1, 16'd0));
        // zero thresholds: any nonzero hold time pulses, zero time never does
        rows.push_back(reg_row(CFG_RPT_DELAY, '0));
        rows.push_back(reg_row(CFG_RPT_INTERVAL, '0));
        rows.push_back(sample_row(8'd9, 1'b1, 16'd0));
        rows.push_back(pinned_row(8'd9, 1'b1, 16'd0, 4'b0000));
        rows.push_back(pinned_row(8'd9, 1'b1, 16'd1, 4'b0001));
        rows.push_back(pinned_row(8'd9, 1'b1, 16'd1, 4'b0001));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_REG_WRITE)
                write_register(rows[i].reg_index, rows[i].reg_data);
            else
                send_sample(rows[i].key, rows[i].down, rows[i].elapsed, rows[i].pinned,
                            rows[i].flags);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    w = DBL_WINDOW_RST; d = RPT_DELAY_RST; iv = RPT_INTERVAL_RST;
                end
                1: begin
                    w = '0; d = '0; iv = '0;
                end
                2: begin
                    w = TIMER_MAX; d = TIMER_MAX; iv = TIMER_MAX;
                end
                3: begin
                    w = TIMER_MAX; d = '0; iv = TIMER_MAX;
                end
                4: begin
                    w = '0; d = TIMER_MAX; iv = '0;
                end
                N_PHASES - 1: begin
                    w  = TIMER_W'($urandom);
                    d  = TIMER_W'($urandom);
                    iv = TIMER_W'($urandom);
                end
                default: begin
                    w  = TIMER_W'($urandom_range(0, 2000));
                    d  = TIMER_W'($urandom_range(0, 3000));
                    iv = TIMER_W'($urandom_range(0, 500));
                end
            endcase
            write_register(CFG_DBL_WINDOW, w);
            write_register(CFG_RPT_DELAY, d);
            write_register(CFG_RPT_INTERVAL, iv);
            run_typing_phase(RANDOM_SAMPLES / N_PHASES);
        end

        key_bus.valid <= 1'b0;
        while (pending_reports.size() != 0 || typed_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d key samples under %0d register writes", samples_seen,
                 regs_written);
        $display("seen: %0d taps, %0d double taps, %0d repeat pulses, %0d mismatches",
                 taps_seen, doubles_seen, pulses_seen, err_count);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ktrd_pkg.sv
hdl/ktrd_if.sv
hdl/ktrd_ram.sv
hdl/ktrd_cfg_regs.sv
hdl/ktrd_eval.sv
hdl/key_tap_repeat_detector.sv
hdl/ktrd_checker.sv
dv/key_tap_repeat_detector_test.sv
